// ===== rtl/core/assert_macros.svh =====
// Assertion macros for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is checked only while reset is released.
`define ASSERT_RST(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion that is checked at every clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/kspm_pkg.sv =====
package kspm_pkg;

    // Field widths.
    localparam int unsigned VoltW = 12;
    localparam int unsigned StepW = 8;
    localparam int unsigned FreqW = 7;
    localparam int unsigned ScrW  = 2;

    // Configuration port.
    localparam int unsigned CfgIdxW  = 3;
    localparam int unsigned CfgDataW = 12;

    // Configuration register indexes.
    localparam logic [CfgIdxW-1:0] RegVoltMin    = 3'd0;
    localparam logic [CfgIdxW-1:0] RegVoltMax    = 3'd1;
    localparam logic [CfgIdxW-1:0] RegFineStep   = 3'd2;
    localparam logic [CfgIdxW-1:0] RegCoarseStep = 3'd3;
    localparam logic [CfgIdxW-1:0] RegFreqMin    = 3'd4;
    localparam logic [CfgIdxW-1:0] RegFreqMax    = 3'd5;

    // Reset values of the configuration registers.
    localparam logic [VoltW-1:0] VoltMinRst    = 12'd2000;
    localparam logic [VoltW-1:0] VoltMaxRst    = 12'd3600;
    localparam logic [StepW-1:0] FineStepRst   = 8'd2;
    localparam logic [StepW-1:0] CoarseStepRst = 8'd5;
    localparam logic [FreqW-1:0] FreqMinRst    = 7'd20;
    localparam logic [FreqW-1:0] FreqMaxRst    = 7'd100;

    // Reset values of the operating state.
    localparam logic [VoltW-1:0] SetpointRst  = 12'd3200;
    localparam logic [FreqW-1:0] FrequencyRst = 7'd50;

endpackage

// ===== rtl/core/keypad_setpoint_menu_controller.sv =====
// Channel   Direction  Handshake         Payload
// keys      in         i_valid/o_stall   i_key_up, i_key_down, i_key_ok, i_key_back
// result    out        o_valid/i_stall   o_screen, o_voltage_setpoint, o_frequency,
//                                        o_start_run, o_stop_run, o_freq_changed, o_redraw
// config    in         i_cfg_we          i_cfg_idx, i_cfg_data
//
// One item per cycle while the output is not stalled: an item is worked on in the cycle it is accepted and its
// result appears in the output register on the next cycle.
// The menu state and the setpoint and frequency registers update in that same edge.
// The input side stalls only while the output register is full and stalled.
// Reset is synchronous and active low; it restores all registers to their defaults.
`include "assert_macros.svh"

module keypad_setpoint_menu_controller (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Configuration writes
    input  logic                            i_cfg_we,
    input  logic [kspm_pkg::CfgIdxW-1:0]    i_cfg_idx,
    input  logic [kspm_pkg::CfgDataW-1:0]   i_cfg_data,
    // Key item
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic                            i_key_up,
    input  logic                            i_key_down,
    input  logic                            i_key_ok,
    input  logic                            i_key_back,
    // Result item
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [kspm_pkg::ScrW-1:0]       o_screen,
    output logic [kspm_pkg::VoltW-1:0]      o_voltage_setpoint,
    output logic [kspm_pkg::FreqW-1:0]      o_frequency,
    output logic                            o_start_run,
    output logic                            o_stop_run,
    output logic                            o_freq_changed,
    output logic                            o_redraw
);
    import kspm_pkg::*;

    typedef enum logic [ScrW-1:0] {
        SCR_START   = 2'd0,
        SCR_FSET    = 2'd1,
        SCR_MEASURE = 2'd2,
        SCR_VSET    = 2'd3
    } t_screen;

    // Configuration registers
    logic [VoltW-1:0] r_volt_min;
    logic [VoltW-1:0] r_volt_max;
    logic [StepW-1:0] r_fine_step;
    logic [StepW-1:0] r_coarse_step;
    logic [FreqW-1:0] r_freq_min;
    logic [FreqW-1:0] r_freq_max;

    // Operating state
    t_screen          r_screen;
    t_screen          n_screen;
    logic [VoltW-1:0] r_setpoint;
    logic [VoltW-1:0] n_setpoint;
    logic [FreqW-1:0] r_frequency;
    logic [FreqW-1:0] n_frequency;

    // Result register
    logic             r_out_valid;
    logic             r_start;
    logic             n_start;
    logic             r_stop;
    logic             n_stop;
    logic             r_fchg;
    logic             n_fchg;
    logic             r_redraw;
    logic             n_redraw;

    logic             accept;
    logic             volt_screen;
    logic [StepW-1:0] step;
    logic [VoltW:0]   up_sum;
    logic [VoltW-1:0] sp_after_up;
    logic [VoltW-1:0] down_diff;
    logic             down_under;
    logic [VoltW-1:0] sp_after_down;
    logic             f_up_ok;
    logic [FreqW-1:0] f_after_up;
    logic             f_down_ok;
    logic [FreqW-1:0] f_after_down;

    // Handshake: the output register frees up when its item is taken.
    assign o_stall = r_out_valid & i_stall;
    assign accept  = i_valid & ~o_stall;

    // Setpoint path: clamped up step, then clamped down step.
    always_comb begin
        volt_screen = (r_screen == SCR_START) || (r_screen == SCR_VSET);
        step        = (r_screen == SCR_START) ? r_fine_step : r_coarse_step;

        up_sum = {1'b0, r_setpoint} + {{(VoltW + 1 - StepW){1'b0}}, step};
        if (i_key_up) begin
            sp_after_up = (up_sum > {1'b0, r_volt_max}) ? r_volt_max : up_sum[VoltW-1:0];
        end else begin
            sp_after_up = r_setpoint;
        end

        down_under = sp_after_up < {{(VoltW - StepW){1'b0}}, step};
        down_diff  = sp_after_up - {{(VoltW - StepW){1'b0}}, step};
        if (i_key_down) begin
            sp_after_down = (down_under || (down_diff < r_volt_min)) ? r_volt_min : down_diff;
        end else begin
            sp_after_down = sp_after_up;
        end
    end

    // Frequency path: step by one inside the limits.
    always_comb begin
        f_up_ok      = i_key_up && (r_frequency < r_freq_max);
        f_after_up   = f_up_ok ? (r_frequency + 1'b1) : r_frequency;
        f_down_ok    = i_key_down && (f_after_up > r_freq_min);
        f_after_down = f_down_ok ? (f_after_up - 1'b1) : f_after_up;
    end

    // Next state and result flags for one item.
    always_comb begin
        n_setpoint  = r_setpoint;
        n_frequency = r_frequency;
        n_screen    = r_screen;
        n_start     = 1'b0;
        n_stop      = 1'b0;
        n_fchg      = 1'b0;
        n_redraw    = 1'b0;

        if (volt_screen) begin
            n_setpoint = sp_after_down;
            n_redraw   = i_key_up | i_key_down;
        end else begin
            n_frequency = f_after_down;
            n_fchg      = f_up_ok | f_down_ok;
            n_redraw    = f_up_ok | f_down_ok;
        end

        // Ok moves forward through the menu.
        if (i_key_ok) begin
            n_redraw = 1'b1;
            unique case (r_screen)
                SCR_START:   n_screen = SCR_FSET;
                SCR_FSET: begin
                    n_screen = SCR_MEASURE;
                    n_start  = 1'b1;
                end
                SCR_MEASURE: n_screen = SCR_VSET;
                SCR_VSET:    n_screen = SCR_MEASURE;
                default:     n_screen = SCR_START;
            endcase
        end

        // Back acts after ok and decides the final screen.
        if (i_key_back) begin
            n_redraw = 1'b1;
            unique case (r_screen)
                SCR_START, SCR_FSET: n_screen = SCR_START;
                SCR_MEASURE, SCR_VSET: begin
                    n_screen = SCR_FSET;
                    n_stop   = 1'b1;
                end
                default: n_screen = SCR_START;
            endcase
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_volt_min    <= VoltMinRst;
            r_volt_max    <= VoltMaxRst;
            r_fine_step   <= FineStepRst;
            r_coarse_step <= CoarseStepRst;
            r_freq_min    <= FreqMinRst;
            r_freq_max    <= FreqMaxRst;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                RegVoltMin:    r_volt_min    <= i_cfg_data[VoltW-1:0];
                RegVoltMax:    r_volt_max    <= i_cfg_data[VoltW-1:0];
                RegFineStep:   r_fine_step   <= i_cfg_data[StepW-1:0];
                RegCoarseStep: r_coarse_step <= i_cfg_data[StepW-1:0];
                RegFreqMin:    r_freq_min    <= i_cfg_data[FreqW-1:0];
                RegFreqMax:    r_freq_max    <= i_cfg_data[FreqW-1:0];
                default: ;
            endcase
        end
    end

    // Menu state, setpoint, frequency and the result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_screen    <= SCR_START;
            r_setpoint  <= SetpointRst;
            r_frequency <= FrequencyRst;
            r_out_valid <= 1'b0;
            r_start     <= 1'b0;
            r_stop      <= 1'b0;
            r_fchg      <= 1'b0;
            r_redraw    <= 1'b0;
        end else begin
            if (accept) begin
                r_screen    <= n_screen;
                r_setpoint  <= n_setpoint;
                r_frequency <= n_frequency;
                r_start     <= n_start;
                r_stop      <= n_stop;
                r_fchg      <= n_fchg;
                r_redraw    <= n_redraw;
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // The result fields come straight from the state and flag registers.
    assign o_valid            = r_out_valid;
    assign o_screen           = r_screen;
    assign o_voltage_setpoint = r_setpoint;
    assign o_frequency        = r_frequency;
    assign o_start_run        = r_start;
    assign o_stop_run         = r_stop;
    assign o_freq_changed     = r_fchg;
    assign o_redraw           = r_redraw;

    // A stop pulse always leaves the menu on the frequency set screen.
    `ASSERT_RST(a_stop_screen, i_clk, i_rst_n, (o_valid && o_stop_run) |-> (r_screen == SCR_FSET), "stop_run without frequency set screen")

    // A start pulse lands on the measure screen unless back overrode it.
    `ASSERT_RST(a_start_screen, i_clk, i_rst_n, (o_valid && o_start_run) |-> ((r_screen == SCR_MEASURE) || (r_screen == SCR_START)), "start_run on an unexpected screen")

    // A frequency step always asks for a redraw.
    `ASSERT_RST(a_fchg_redraw, i_clk, i_rst_n, (o_valid && o_freq_changed) |-> o_redraw, "freq_changed without redraw")

    // The setpoint and frequency move only when an item is accepted.
    `ASSERT_RST(a_state_hold, i_clk, i_rst_n, !accept |=> ($stable(r_setpoint) && $stable(r_frequency)), "state changed without an item")

    // The input side is stalled only while a result is waiting.
    `ASSERT_ALWAYS(a_stall_full, i_clk, o_stall |-> r_out_valid, "stall with an empty output register")

endmodule
